// ===== hdl/wfjr_pkg.sv =====
// Shared constants, register codes and controller/datapath interface structs
// for the waypoint follower with stall recovery. No dependencies.
package wfjr_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int SEARCH_HALF = 5;
   localparam int IDX_W       = $clog2(MAX_POINTS);      // table address
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);  // target index, route length
   localparam int COORD_W     = 14;
   localparam int RADIUS_W    = 12;
   localparam int LIMIT_W     = 16;
   localparam int ROUTE_W     = 11;
   localparam int R2_W        = 2 * RADIUS_W;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int SQ_W        = 2 * COORD_W + 1;
   localparam int DIST_W      = SQ_W + 1;

   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_REACH_RADIUS = 2'd0;
   localparam logic [1:0] REG_STALL_LIMIT  = 2'd1;
   localparam logic [1:0] REG_ROUTE_LENGTH = 2'd2;

   // item kinds on req_tuser
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(50);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(100);

   typedef struct packed {
      logic capture;    // latch sample position, clear stall flag
      logic load_wr;    // write waypoint from input word
      logic dist_rd;    // read current target into distance pipe
      logic fetch_rd;   // read current target for result coordinates
      logic srch_init;  // set search window, enter search mode
      logic srch_step;  // issue next search read
      logic tgt_inc;
      logic tgt_best;   // jump to nearest found, flag stall
      logic tgt_cap;
      logic cnt_clear;
      logic cnt_inc;
      logic out_load;
   } wfjr_cmd_type;

   typedef struct packed {
      logic active;      // current target below route length
      logic dist_valid;
      logic reach;
      logic at_limit;
      logic srch_last;
      logic pipe_empty;
      logic out_free;
   } wfjr_stat_type;

endpackage

// ===== hdl/wfjr_dpath.sv =====
// Datapath: waypoint memory, config registers, squared-distance pipe, nearest
// search, target/stall state and result register. Uses wfjr_pkg.
module wfjr_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  wfjr_pkg::wfjr_cmd_type             cmd,
   output wfjr_pkg::wfjr_stat_type            stat,
   input  logic [wfjr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [wfjr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wfjr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wfjr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wfjr_pkg::CSR_DATA_W-1:0]    csr_prdata
);

   localparam int IW = wfjr_pkg::IDX_W;
   localparam int CW = wfjr_pkg::CNT_W;
   localparam int XW = wfjr_pkg::COORD_W;

   // input word fields
   logic [IW-1:0]        load_index;
   logic signed [XW-1:0] load_x, load_y, pos_x, pos_y;
   assign load_index = req_tdata[9:0];
   assign load_x     = req_tdata[23:10];
   assign load_y     = req_tdata[37:24];
   assign pos_x      = req_tdata[51:38];
   assign pos_y      = req_tdata[65:52];

   // config registers
   logic [wfjr_pkg::RADIUS_W-1:0] radius_ff;
   logic [wfjr_pkg::LIMIT_W-1:0]  limit_ff;
   logic [wfjr_pkg::ROUTE_W-1:0]  route_ff;
   logic [wfjr_pkg::R2_W-1:0]     r2_ff;
   logic                          csr_wr;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= wfjr_pkg::RADIUS_RESET;
         limit_ff  <= wfjr_pkg::LIMIT_RESET;
         route_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            wfjr_pkg::REG_REACH_RADIUS: radius_ff <= csr_pwdata[wfjr_pkg::RADIUS_W-1:0];
            wfjr_pkg::REG_STALL_LIMIT:  limit_ff  <= csr_pwdata[wfjr_pkg::LIMIT_W-1:0];
            wfjr_pkg::REG_ROUTE_LENGTH: route_ff  <= csr_pwdata[wfjr_pkg::ROUTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         wfjr_pkg::REG_REACH_RADIUS: csr_prdata = wfjr_pkg::CSR_DATA_W'(radius_ff);
         wfjr_pkg::REG_STALL_LIMIT:  csr_prdata = wfjr_pkg::CSR_DATA_W'(limit_ff);
         wfjr_pkg::REG_ROUTE_LENGTH: csr_prdata = wfjr_pkg::CSR_DATA_W'(route_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // radius squared, refreshed every cycle
   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   logic [CW-1:0] len_eff;
   assign len_eff = (int'(route_ff) > wfjr_pkg::MAX_POINTS) ?
                    CW'(wfjr_pkg::MAX_POINTS) : CW'(route_ff);

   // state
   logic [CW-1:0]                cur_ff, cur_in;
   logic [wfjr_pkg::LIMIT_W-1:0] cnt_ff, cnt_in;
   logic                         stall_ff, stall_in;
   logic signed [XW-1:0]         px_ff, py_ff;

   // search
   logic [CW-1:0] srch_ff, srch_in, hi_ff, hi_in;
   logic [CW:0]   hi_raw;
   logic [CW-1:0] lo;
   logic          mode_ff, mode_in;
   logic          first_ff, first_in;
   logic [CW-1:0] best_ff, best_in;
   logic [wfjr_pkg::DIST_W-1:0] best_d_ff, best_d_in;

   // memory and distance pipe
   logic [2*XW-1:0]      mem [wfjr_pkg::MAX_POINTS];
   logic signed [XW-1:0] rd_x_ff, rd_y_ff;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   logic                 p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [CW-1:0]        p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic signed [wfjr_pkg::DIFF_W-1:0] dx, dy;
   logic signed [2*wfjr_pkg::DIFF_W-1:0] sqx_full, sqy_full;
   logic [wfjr_pkg::SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [wfjr_pkg::DIST_W-1:0] dist_ff;

   assign rd_en   = cmd.dist_rd || cmd.fetch_rd || cmd.srch_step;
   assign rd_addr = cmd.srch_step ? srch_ff[IW-1:0] : cur_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[load_index] <= {load_x, load_y};
      end
      if (rd_en) begin
         {rd_x_ff, rd_y_ff} <= mem[rd_addr];
      end
   end

   assign dx       = DIFF_W_ext(rd_x_ff) - DIFF_W_ext(px_ff);
   assign dy       = DIFF_W_ext(rd_y_ff) - DIFF_W_ext(py_ff);
   assign sqx_full = dx * dx;
   assign sqy_full = dy * dy;

   function automatic logic signed [wfjr_pkg::DIFF_W-1:0] DIFF_W_ext(
      input logic signed [XW-1:0] v);
      DIFF_W_ext = {v[XW-1], v};
   endfunction

   always_ff @(posedge clock) begin
      sqx_ff    <= sqx_full[wfjr_pkg::SQ_W-1:0];
      sqy_ff    <= sqy_full[wfjr_pkg::SQ_W-1:0];
      dist_ff   <= wfjr_pkg::DIST_W'(sqx_ff) + wfjr_pkg::DIST_W'(sqy_ff);
      p1_idx_ff <= srch_ff;
      p2_idx_ff <= p1_idx_ff;
      p3_idx_ff <= p2_idx_ff;
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.dist_rd || cmd.srch_step;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   // search window, clamped to valid indices
   assign lo     = (cur_ff > CW'(wfjr_pkg::SEARCH_HALF)) ?
                   cur_ff - CW'(wfjr_pkg::SEARCH_HALF) : '0;
   assign hi_raw = {1'b0, cur_ff} + (CW+1)'(wfjr_pkg::SEARCH_HALF);

   always_comb begin
      srch_in   = srch_ff;
      hi_in     = hi_ff;
      mode_in   = mode_ff;
      first_in  = first_ff;
      best_in   = best_ff;
      best_d_in = best_d_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      stall_in  = stall_ff;
      if (cmd.srch_init) begin
         srch_in  = lo;
         hi_in    = (hi_raw > {1'b0, len_eff - 1'b1}) ? len_eff - 1'b1 : hi_raw[CW-1:0];
         mode_in  = 1'b1;
         first_in = 1'b1;
      end
      if (cmd.srch_step) begin
         srch_in = srch_ff + 1'b1;
      end
      // running minimum, strict compare keeps the lowest index on ties
      if (mode_ff && p3_valid_ff && (first_ff || dist_ff < best_d_ff)) begin
         best_in   = p3_idx_ff;
         best_d_in = dist_ff;
         first_in  = 1'b0;
      end
      if (cmd.capture) begin
         stall_in = 1'b0;
      end
      if (cmd.tgt_inc) begin
         cur_in = cur_ff + 1'b1;
      end else if (cmd.tgt_best) begin
         cur_in   = best_ff;
         stall_in = 1'b1;
         mode_in  = 1'b0;
      end else if (cmd.tgt_cap && cur_ff > len_eff) begin
         cur_in = len_eff;
      end
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc && cnt_ff != '1) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      srch_ff   <= srch_in;
      hi_ff     <= hi_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      first_ff  <= first_in;
      if (cmd.capture) begin
         px_ff <= pos_x;
         py_ff <= pos_y;
      end
      if (reset) begin
         cur_ff   <= '0;
         cnt_ff   <= '0;
         stall_ff <= 1'b0;
         mode_ff  <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         stall_ff <= stall_in;
         mode_ff  <= mode_in;
      end
   end

   // result register
   logic                 out_valid_ff;
   logic [CW-1:0]        out_idx_ff;
   logic signed [XW-1:0] out_x_ff, out_y_ff;
   logic                 out_stall_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_idx_ff   <= cur_ff;
         out_x_ff     <= stat.active ? rd_x_ff : '0;
         out_y_ff     <= stat.active ? rd_y_ff : '0;
         out_stall_ff <= stall_ff;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_y_ff, out_x_ff, out_idx_ff};
   assign rsp_tuser  = out_stall_ff;

   assign stat.active     = cur_ff < len_eff;
   assign stat.dist_valid = p3_valid_ff;
   assign stat.reach      = dist_ff <= wfjr_pkg::DIST_W'(r2_ff);
   assign stat.at_limit   = cnt_ff >= limit_ff;
   assign stat.srch_last  = srch_ff == hi_ff;
   assign stat.pipe_empty = !p1_valid_ff && !p2_valid_ff && !p3_valid_ff;
   assign stat.out_free   = !out_valid_ff || rsp_tready;

endmodule

// ===== hdl/wfjr_ctrl.sv =====
// Controller state machine: input handshake and per-sample sequencing of
// the datapath. Uses wfjr_pkg.
module wfjr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tuser,
   output logic                     req_tready,
   input  wfjr_pkg::wfjr_stat_type  stat,
   output wfjr_pkg::wfjr_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIST   = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_FETCH  = 3'd5;
   localparam logic [2:0] S_READ   = 3'd6;
   localparam logic [2:0] S_DATA   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == wfjr_pkg::KIND_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (stat.active) begin
               cmd.dist_rd = 1'b1;
               state_in    = S_DIST;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_DIST: begin
            if (stat.dist_valid) begin
               if (stat.reach) begin
                  cmd.tgt_inc   = 1'b1;
                  cmd.cnt_clear = 1'b1;
                  state_in      = S_FETCH;
               end else if (stat.at_limit) begin
                  cmd.srch_init = 1'b1;
                  state_in      = S_SEARCH;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_FETCH;
               end
            end
         end
         S_SEARCH: begin
            cmd.srch_step = 1'b1;
            if (stat.srch_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (stat.pipe_empty) begin
               cmd.tgt_best  = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.tgt_cap = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.fetch_rd = 1'b1;
            state_in     = S_DATA;
         end
         S_DATA: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/waypoint_follow_jam_recovery.sv =====
// Top level of the waypoint follower with stall recovery: wires the
// controller to the datapath. Uses wfjr_pkg, wfjr_ctrl, wfjr_dpath.
//
// Usage:
//   req channel carries load words (tuser 0) that write one waypoint into the
//   1024-entry table, and position samples (tuser 1). A load gives no result.
//   Each sample gives exactly one rsp word: the target index after the
//   sample, its coordinates (zero once the route is done) and the stall flag
//   in tuser.
//   A sample passes through the check, distance, fetch, read and data states;
//   when the stall search runs it also makes one table read per candidate
//   through the one read port and lets the distance pipe drain. A finished
//   route skips the distance state. One sample is worked on at a time;
//   req_tready is high only while the block is idle.
//   A finished word waits in the rsp register; the next word is accepted
//   while it waits, and a further result stalls until rsp_tready takes it.
//   Reset clears target index, stall counter and rsp_tvalid, and sets the
//   registers to radius 50, limit 100, route length 0. Table contents are
//   undefined until loaded. Registers are to be written through the csr port
//   only while the block is idle; the block itself does not enforce this.
module waypoint_follow_jam_recovery (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] load_index, [23:10] load_x, [37:24] load_y, [51:38] pos_x,
   // [65:52] pos_y, [71:66] zero
   input  logic [wfjr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [10:0] target_index, [24:11] target_x, [38:25] target_y, [39] zero
   output logic [wfjr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] stall_event
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wfjr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wfjr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wfjr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   wfjr_pkg::wfjr_cmd_type  cmd;
   wfjr_pkg::wfjr_stat_type stat;

   assign csr_pready = 1'b1;

   wfjr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wfjr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

// ===== hdl/wfjr_checker.sv =====
// Port-level checks for waypoint_follow_jam_recovery, bound to the top level.
// Uses wfjr_pkg for widths.
module wfjr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [wfjr_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wfjr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [wfjr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [wfjr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [wfjr_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                            csr_pready
);

   // a held result word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // a load word never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == wfjr_pkg::KIND_LOAD |=> !$rose(rsp_tvalid))
      else $error("result appeared after a load word");

   // a sample occupies the block: input closes right after it
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == wfjr_pkg::KIND_SAMPLE |=> !req_tready)
      else $error("input still open after a sample");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind waypoint_follow_jam_recovery wfjr_checker u_wfjr_checker (.*);

// ===== tb/tb_waypoint_follow_jam_recovery.sv =====
// Self-checking testbench for waypoint_follow_jam_recovery: waypoint table loads and position
// samples in, target words out, checked against an in-bench follower model.
// Depends on wfjr_pkg and the waypoint_follow_jam_recovery top level only.
module tb_waypoint_follow_jam_recovery;
   import wfjr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRACK          = 0;     // model advanced on accepted words
   localparam int PLAN           = 1;     // model advanced as stimulus is queued
   localparam int ITEM_TARGET    = 1950;
   localparam int QUIET_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 400;
   localparam int BIG_PHASE      = 14;
   localparam int COORD_MAX      = 8191;
   localparam int COORD_MIN      = -8192;

   typedef struct packed {
      logic                kind;
      logic [IDX_W-1:0]    load_index;
      logic [COORD_W-1:0]  load_x;
      logic [COORD_W-1:0]  load_y;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
   } route_req_t;

   typedef struct packed {
      logic [CNT_W-1:0]    index;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic                stall;
   } target_rsp_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   waypoint_follow_jam_recovery u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // follower models: [TRACK] and [PLAN]
   logic [COORD_W-1:0] way_x [2][MAX_POINTS];
   logic [COORD_W-1:0] way_y [2][MAX_POINTS];
   int                 tgt_idx [2];
   int                 miss_cnt [2];
   int                 cfg_radius [2];
   int                 cfg_limit [2];
   int                 cfg_route [2];

   route_req_t   pending_q [$];
   target_rsp_t  target_exp_q [$];
   bit           slot_loaded [MAX_POINTS];
   int           items_sent = 0;
   int           mismatches = 0;
   int           hold_ask = 0;

   function automatic longint sq_dist(input int m, input int idx, input int px, input int py);
      int dx;
      int dy;
      dx = int'($signed(way_x[m][idx])) - px;
      dy = int'($signed(way_y[m][idx])) - py;
      return longint'(dx) * dx + longint'(dy) * dy;
   endfunction

   // one word through the follower; returns 1 when it yields a target word
   function automatic bit follow_step(input int m, input route_req_t it, output target_rsp_t res);
      int     len;
      int     t;
      int     lo;
      int     hi;
      int     best;
      int     i;
      int     px;
      int     py;
      longint r2;
      longint d;
      longint best_d;
      bit     stall;
      res   = '0;
      stall = 1'b0;
      len   = (cfg_route[m] < MAX_POINTS) ? cfg_route[m] : MAX_POINTS;
      if (it.kind == KIND_LOAD) begin
         way_x[m][it.load_index] = it.load_x;
         way_y[m][it.load_index] = it.load_y;
         return 1'b0;
      end
      t  = tgt_idx[m];
      px = $signed(it.pos_x);
      py = $signed(it.pos_y);
      if (t < len) begin
         r2 = longint'(cfg_radius[m]) * cfg_radius[m];
         if (sq_dist(m, t, px, py) <= r2) begin
            t++;
            miss_cnt[m] = 0;
         end else if (miss_cnt[m] >= cfg_limit[m]) begin
            // nearest in the window, first index wins a tie
            lo = (t > SEARCH_HALF) ? t - SEARCH_HALF : 0;
            hi = t + SEARCH_HALF;
            if (hi > len - 1) hi = len - 1;
            best   = lo;
            best_d = sq_dist(m, lo, px, py);
            for (i = lo + 1; i <= hi; i++) begin
               d = sq_dist(m, i, px, py);
               if (d < best_d) begin
                  best_d = d;
                  best   = i;
               end
            end
            t           = best;
            miss_cnt[m] = 0;
            stall       = 1'b1;
         end else if (miss_cnt[m] < 65535) begin
            miss_cnt[m]++;
         end
      end
      if (t > len) t = len;
      tgt_idx[m] = t;
      res.index  = CNT_W'(t);
      if (t < len) begin
         res.x = way_x[m][t];
         res.y = way_y[m][t];
      end
      res.stall = stall;
      return 1'b1;
   endfunction

   function automatic int clamp14(input int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic int rand14();
      return int'($urandom_range(0, 16383)) - 8192;
   endfunction

   function automatic route_req_t mk_load(input int slot, input int x, input int y);
      route_req_t it;
      it.kind       = KIND_LOAD;
      it.load_index = IDX_W'(slot);
      it.load_x     = COORD_W'(x);
      it.load_y     = COORD_W'(y);
      it.pos_x      = COORD_W'($urandom);
      it.pos_y      = COORD_W'($urandom);
      return it;
   endfunction

   function automatic route_req_t mk_sample(input int x, input int y);
      route_req_t it;
      it.kind       = KIND_SAMPLE;
      it.load_index = IDX_W'($urandom);
      it.load_x     = COORD_W'($urandom);
      it.load_y     = COORD_W'($urandom);
      it.pos_x      = COORD_W'(x);
      it.pos_y      = COORD_W'(y);
      return it;
   endfunction

   task automatic push_item(input route_req_t it);
      target_rsp_t unused;
      pending_q.push_back(it);
      void'(follow_step(PLAN, it, unused));
      if (it.kind == KIND_LOAD) slot_loaded[it.load_index] = 1'b1;
      items_sent++;
   endtask

   // sender stops until the block has drained, then lets it settle
   task automatic wait_quiet();
      while (pending_q.size() != 0 || req_tvalid || target_exp_q.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int val);
      int m;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      for (m = 0; m < 2; m++) begin
         if (idx == REG_REACH_RADIUS) cfg_radius[m] = val & 32'hFFF;
         else if (idx == REG_STALL_LIMIT) cfg_limit[m] = val & 32'hFFFF;
         else if (idx == REG_ROUTE_LENGTH) cfg_route[m] = val & 32'h7FF;
      end
   endtask

   // ---------------- driver ----------------
   route_req_t send_item;
   int         send_left = 0;
   int         gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_left  <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            send_item  = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {6'b0, send_item.pos_y, send_item.pos_x, send_item.load_y,
                           send_item.load_x, send_item.load_index};
            req_tuser  <= send_item.kind;
            if (send_left <= 1) begin
               send_left <= $urandom_range(1, 24);
               gap_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               send_left <= send_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------- receiver ----------------
   int hold_seen = 0;
   int hold_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   bit rx_ready;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= LONG_HOLD;
            rx_ready  = 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rx_ready  = 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      <= $urandom_range(0, 2);
               rx_mode_left <= $urandom_range(16, 200);
            end else begin
               rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
               0: rx_ready = 1'b1;
               1: rx_ready = $urandom_range(0, 1);
               default: rx_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= rx_ready;
      end
   end

   // ---------------- monitor / scoreboard ----------------
   route_req_t  seen_req;
   target_rsp_t seen_rsp;
   target_rsp_t want_rsp;
   target_rsp_t next_rsp;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_req.kind       = req_tuser;
            seen_req.load_index = req_tdata[9:0];
            seen_req.load_x     = req_tdata[23:10];
            seen_req.load_y     = req_tdata[37:24];
            seen_req.pos_x      = req_tdata[51:38];
            seen_req.pos_y      = req_tdata[65:52];
            if (follow_step(TRACK, seen_req, next_rsp)) target_exp_q.push_back(next_rsp);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.index = rsp_tdata[10:0];
            seen_rsp.x     = rsp_tdata[24:11];
            seen_rsp.y     = rsp_tdata[38:25];
            seen_rsp.stall = rsp_tuser;
            if (target_exp_q.size() == 0) begin
               $error("unexpected target word: index %0d", seen_rsp.index);
               mismatches++;
            end else begin
               want_rsp = target_exp_q.pop_front();
               if (seen_rsp.index !== want_rsp.index) begin
                  $error("target_index: expected %0d, got %0d", want_rsp.index, seen_rsp.index);
                  mismatches++;
               end
               if (seen_rsp.x !== want_rsp.x) begin
                  $error("target_x: expected %0d, got %0d",
                         $signed(want_rsp.x), $signed(seen_rsp.x));
                  mismatches++;
               end
               if (seen_rsp.y !== want_rsp.y) begin
                  $error("target_y: expected %0d, got %0d",
                         $signed(want_rsp.y), $signed(seen_rsp.y));
                  mismatches++;
               end
               if (seen_rsp.stall !== want_rsp.stall) begin
                  $error("stall_event: expected %0d, got %0d", want_rsp.stall, seen_rsp.stall);
                  mismatches++;
               end
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_q.size() == 0 && !req_tvalid && target_exp_q.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      int m;
      int s;
      int n;
      int k;
      int phase;
      int len;
      int t;
      int wx;
      int wy;
      int r;
      int half;
      int rr;
      int x;
      int pick;
      int new_radius;
      int new_limit;
      int new_route;

      for (m = 0; m < 2; m++) begin
         tgt_idx[m]    = 0;
         miss_cnt[m]   = 0;
         cfg_radius[m] = RADIUS_RESET;
         cfg_limit[m]  = LIMIT_RESET;
         cfg_route[m]  = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty route, then a small table with extremes and a tie cluster
      push_item(mk_sample(rand14(), rand14()));
      push_item(mk_load(0, COORD_MIN, COORD_MIN));
      push_item(mk_load(1, COORD_MAX, COORD_MAX));
      for (s = 2; s <= 6; s++) push_item(mk_load(s, 0, 0));
      push_item(mk_load(7, COORD_MAX, COORD_MIN));
      push_item(mk_load(8, COORD_MIN, COORD_MAX));
      push_item(mk_load(9, 100, 100));
      push_item(mk_load(10, 200, -300));
      push_item(mk_load(MAX_POINTS - 1, COORD_MAX, COORD_MAX));
      wait_quiet();
      csr_write(REG_STALL_LIMIT, 0);
      csr_write(REG_ROUTE_LENGTH, 11);

      push_item(mk_sample(COORD_MIN, COORD_MIN));          // exact hit
      push_item(mk_sample(COORD_MAX - 50, COORD_MAX));     // exactly on the radius
      push_item(mk_sample(51, 0));                         // miss, search over a tie
      push_item(mk_sample(0, 50));
      push_item(mk_sample(COORD_MAX, COORD_MIN));          // search jumps forward
      wait_quiet();
      csr_write(REG_ROUTE_LENGTH, 5);                      // target now past the end
      push_item(mk_sample(rand14(), rand14()));
      wait_quiet();
      csr_write(REG_REACH_RADIUS, 0);
      csr_write(REG_STALL_LIMIT, 3);
      csr_write(REG_ROUTE_LENGTH, 11);
      push_item(mk_sample(0, 0));
      push_item(mk_sample(1, 0));
      wait_quiet();
      csr_write(REG_REACH_RADIUS, 4095);
      csr_write(REG_STALL_LIMIT, 65535);
      push_item(mk_sample(4095, 0));
      push_item(mk_sample(COORD_MIN, COORD_MAX));
      wait_quiet();

      // random phases
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         case ($urandom_range(0, 5))
            0: new_radius = 0;
            1: new_radius = 4095;
            2, 3: new_radius = $urandom_range(10, 200);
            default: new_radius = $urandom_range(0, 4095);
         endcase
         case ($urandom_range(0, 6))
            0, 1: new_limit = $urandom_range(0, 3);
            2: new_limit = 0;
            3: new_limit = $urandom_range(4, 40);
            4: new_limit = 65535;
            default: new_limit = $urandom_range(0, 10);
         endcase
         if (phase == BIG_PHASE) new_route = MAX_POINTS;
         else begin
            case ($urandom_range(0, 9))
               0: new_route = 0;
               1: new_route = 1;
               2: new_route = $urandom_range(41, 300);
               default: new_route = $urandom_range(2, 40);
            endcase
         end
         // every slot on the route must hold a waypoint before samples run
         for (s = 0; s < new_route; s++)
            if (!slot_loaded[s]) push_item(mk_load(s, rand14(), rand14()));
         wait_quiet();
         csr_write(REG_REACH_RADIUS, new_radius);
         csr_write(REG_STALL_LIMIT, new_limit);
         csr_write(REG_ROUTE_LENGTH, new_route);

         n = $urandom_range(40, 120);
         for (k = 0; k < n; k++) begin
            len  = (cfg_route[PLAN] < MAX_POINTS) ? cfg_route[PLAN] : MAX_POINTS;
            t    = tgt_idx[PLAN];
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               if ($urandom_range(0, 1) == 0 && len > 0) s = $urandom_range(0, len - 1);
               else s = $urandom_range(0, MAX_POINTS - 1);
               push_item(mk_load(s, rand14(), rand14()));
            end else if (t < len && pick < 65) begin
               wx   = $signed(way_x[PLAN][t]);
               wy   = $signed(way_y[PLAN][t]);
               half = cfg_radius[PLAN] / 2;
               push_item(mk_sample(clamp14(wx + int'($urandom_range(0, 2 * half)) - half),
                                   clamp14(wy + int'($urandom_range(0, 2 * half)) - half)));
            end else if (t < len && pick < 72) begin
               // right on the radius, or one past it
               wx = $signed(way_x[PLAN][t]);
               wy = $signed(way_y[PLAN][t]);
               r  = cfg_radius[PLAN];
               rr = r + $urandom_range(0, 1);
               x  = wx + rr;
               if (x > COORD_MAX) x = wx - rr;
               push_item(mk_sample(x, wy));
            end else begin
               push_item(mk_sample(rand14(), rand14()));
            end
         end
         if (phase % 6 == 3) hold_ask <= hold_ask + 1;
         wait_quiet();
      end

      wait_quiet();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wfjr_pkg.sv
hdl/wfjr_dpath.sv
hdl/wfjr_ctrl.sv
hdl/waypoint_follow_jam_recovery.sv
hdl/wfjr_checker.sv
tb/tb_waypoint_follow_jam_recovery.sv
